// ===== rtl/ppn_pkg.sv =====
package ppn_pkg;

  // Fixed field and accumulator widths.
  localparam int ACC_W     = 42;
  localparam int SUM_W     = 25;
  localparam int D_W       = 59;
  localparam int TOTAL_W   = 9;

  // Shared multiplier: a signed 25 by 26 bit product.
  localparam int MUL_A_W   = 25;
  localparam int MUL_B_W   = 26;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  // The 42 bit normal is split into two 21 bit chunks for the dot product.
  localparam int CHUNK_W   = ACC_W / 2;

  // Exact dot product of three 25 by 42 bit products, and its magnitude.
  localparam int DOT_W     = 70;
  localparam int DOT_TERMS = 6;
  localparam int STEP_W    = $clog2(DOT_W);

  // Multiplier operand selection codes.
  localparam int SEL_W = 4;
  localparam logic [SEL_W-1:0] SEL_EA  = 4'd0;
  localparam logic [SEL_W-1:0] SEL_EB  = 4'd1;
  localparam logic [SEL_W-1:0] SEL_EC  = 4'd2;
  localparam logic [SEL_W-1:0] SEL_DXL = 4'd3;
  localparam logic [SEL_W-1:0] SEL_DXH = 4'd4;
  localparam logic [SEL_W-1:0] SEL_DYL = 4'd5;
  localparam logic [SEL_W-1:0] SEL_DYH = 4'd6;
  localparam logic [SEL_W-1:0] SEL_DZL = 4'd7;
  localparam logic [SEL_W-1:0] SEL_DZH = 4'd8;

  typedef struct packed {
    logic             load_vertex;
    logic             load_close;
    logic             mul_en;
    logic [SEL_W-1:0] sel;
    logic             div_init;
    logic             div_step;
    logic             load_out;
  } ppn_cmd_t;

  typedef struct packed {
    logic is_last;
  } ppn_status_t;

endpackage

// ===== rtl/ppn_if.sv =====
interface ppn_vertex_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         is_last;

  modport source (output valid, coord_x, coord_y, coord_z, is_last, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, is_last, output ready);
endinterface

interface ppn_plane_if;
  import ppn_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ACC_W-1:0]   normal_a;
  logic signed [ACC_W-1:0]   normal_b;
  logic signed [ACC_W-1:0]   normal_c;
  logic signed [D_W-1:0]     offset_d;
  logic        [TOTAL_W-1:0] vertex_total;
  logic                      overflow;

  modport source (output valid, normal_a, normal_b, normal_c, offset_d, vertex_total,
                  overflow, input ready);
  modport sink (input valid, normal_a, normal_b, normal_c, offset_d, vertex_total,
                overflow, output ready);
endinterface

// ===== rtl/ppn_ctrl.sv =====
module ppn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ppn_pkg::ppn_status_t status,
  output ppn_pkg::ppn_cmd_t    cmd
);
  import ppn_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EA    = 4'd1;
  localparam logic [3:0] S_EB    = 4'd2;
  localparam logic [3:0] S_EC    = 4'd3;
  localparam logic [3:0] S_CA    = 4'd4;
  localparam logic [3:0] S_CB    = 4'd5;
  localparam logic [3:0] S_CC    = 4'd6;
  localparam logic [3:0] S_DOT   = 4'd7;
  localparam logic [3:0] S_DWAIT = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_LOAD  = 4'd11;

  logic [3:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid;
    in_ready       = 1'b0;
    cmd            = '0;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_vertex = 1'b1;
          state_next      = S_EA;
        end
      end
      S_EA, S_CA: begin
        cmd.mul_en = 1'b1;
        cmd.sel    = SEL_EA;
        state_next = (state == S_EA) ? S_EB : S_CB;
      end
      S_EB, S_CB: begin
        cmd.mul_en = 1'b1;
        cmd.sel    = SEL_EB;
        state_next = (state == S_EB) ? S_EC : S_CC;
      end
      S_EC: begin
        cmd.mul_en = 1'b1;
        cmd.sel    = SEL_EC;
        if (status.is_last) begin
          cmd.load_close = 1'b1;
          state_next     = S_CA;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CC: begin
        cmd.mul_en = 1'b1;
        cmd.sel    = SEL_EC;
        step_next  = '0;
        state_next = S_DOT;
      end
      S_DOT: begin
        cmd.mul_en = 1'b1;
        unique case (step[2:0])
          3'd0:    cmd.sel = SEL_DXL;
          3'd1:    cmd.sel = SEL_DXH;
          3'd2:    cmd.sel = SEL_DYL;
          3'd3:    cmd.sel = SEL_DYH;
          3'd4:    cmd.sel = SEL_DZL;
          default: cmd.sel = SEL_DZH;
        endcase
        if (step == STEP_W'(DOT_TERMS - 1)) begin
          step_next  = '0;
          state_next = S_DWAIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DWAIT: begin
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(DOT_W - 1)) begin
          state_next = S_LOAD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_LOAD: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/ppn_datapath.sv =====
module ppn_datapath #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ppn_pkg::ppn_cmd_t                     cmd,
  output ppn_pkg::ppn_status_t                  status,
  input  logic signed [COORD_BITS-1:0]          coord_x,
  input  logic signed [COORD_BITS-1:0]          coord_y,
  input  logic signed [COORD_BITS-1:0]          coord_z,
  input  logic                                  is_last,
  output logic signed [ppn_pkg::ACC_W-1:0]      normal_a,
  output logic signed [ppn_pkg::ACC_W-1:0]      normal_b,
  output logic signed [ppn_pkg::ACC_W-1:0]      normal_c,
  output logic signed [ppn_pkg::D_W-1:0]        offset_d,
  output logic        [ppn_pkg::TOTAL_W-1:0]    vertex_total,
  output logic                                  overflow
);
  import ppn_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // Polygon state.
  logic signed [COORD_BITS-1:0] first_x, first_y, first_z;
  logic signed [COORD_BITS-1:0] prev_x, prev_y, prev_z;
  logic        [ACC_W-1:0]      acc_a, acc_b, acc_c;
  logic        [SUM_W-1:0]      sum_x, sum_y, sum_z;
  logic        [CNT_W-1:0]      count;
  logic                         ovf_seen;
  logic                         last_q;

  // Edge endpoints for the multiplier.
  logic signed [COORD_BITS-1:0] ei_x, ei_y, ei_z;
  logic signed [COORD_BITS-1:0] ej_x, ej_y, ej_z;

  // Multiplier and accumulation.
  logic signed [MUL_A_W-1:0] a_op;
  logic signed [MUL_B_W-1:0] b_op;
  logic signed [PROD_W-1:0]  prod;
  logic                      acc_en_q;
  logic        [SEL_W-1:0]   acc_sel_q;
  logic signed [DOT_W-1:0]   dot;

  // Divider.
  logic [DOT_W-1:0] quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W:0]   trial;
  logic             trial_ge;
  logic             neg_q;
  logic [DOT_W-1:0] d_full;

  assign status.is_last = last_q;

  always_comb begin
    unique case (cmd.sel)
      SEL_EA: begin
        a_op = MUL_A_W'(ei_y) - MUL_A_W'(ej_y);
        b_op = MUL_B_W'(ei_z) + MUL_B_W'(ej_z);
      end
      SEL_EB: begin
        a_op = MUL_A_W'(ei_z) - MUL_A_W'(ej_z);
        b_op = MUL_B_W'(ei_x) + MUL_B_W'(ej_x);
      end
      SEL_EC: begin
        a_op = MUL_A_W'(ei_x) - MUL_A_W'(ej_x);
        b_op = MUL_B_W'(ei_y) + MUL_B_W'(ej_y);
      end
      SEL_DXL: begin
        a_op = $signed(sum_x);
        b_op = MUL_B_W'({1'b0, acc_a[CHUNK_W-1:0]});
      end
      SEL_DXH: begin
        a_op = $signed(sum_x);
        b_op = MUL_B_W'($signed(acc_a[ACC_W-1:CHUNK_W]));
      end
      SEL_DYL: begin
        a_op = $signed(sum_y);
        b_op = MUL_B_W'({1'b0, acc_b[CHUNK_W-1:0]});
      end
      SEL_DYH: begin
        a_op = $signed(sum_y);
        b_op = MUL_B_W'($signed(acc_b[ACC_W-1:CHUNK_W]));
      end
      SEL_DZL: begin
        a_op = $signed(sum_z);
        b_op = MUL_B_W'({1'b0, acc_c[CHUNK_W-1:0]});
      end
      SEL_DZH: begin
        a_op = $signed(sum_z);
        b_op = MUL_B_W'($signed(acc_c[ACC_W-1:CHUNK_W]));
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // Restoring division, one quotient bit a cycle.
  assign trial    = {rem, quo[DOT_W-1]};
  assign trial_ge = (trial >= {1'b0, count});
  assign d_full   = neg_q ? quo : (~quo + 1'b1);

  // Payload and datapath registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.load_vertex) begin
      if (count == '0) begin
        ei_x <= coord_x;
        ei_y <= coord_y;
        ei_z <= coord_z;
      end else begin
        ei_x <= prev_x;
        ei_y <= prev_y;
        ei_z <= prev_z;
      end
      ej_x <= coord_x;
      ej_y <= coord_y;
      ej_z <= coord_z;
    end else if (cmd.load_close) begin
      ei_x <= ej_x;
      ei_y <= ej_y;
      ei_z <= ej_z;
      ej_x <= first_x;
      ej_y <= first_y;
      ej_z <= first_z;
    end
    if (cmd.mul_en) begin
      prod <= a_op * b_op;
    end
    acc_sel_q <= cmd.sel;
    if (cmd.div_init) begin
      neg_q <= dot[DOT_W-1];
      quo   <= dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
      rem   <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[DOT_W-2:0], trial_ge};
      rem <= trial_ge ? CNT_W'(trial - {1'b0, count}) : trial[CNT_W-1:0];
    end
    if (cmd.load_out) begin
      normal_a     <= $signed(acc_a);
      normal_b     <= $signed(acc_b);
      normal_c     <= $signed(acc_c);
      offset_d     <= $signed(d_full[D_W-1:0]);
      vertex_total <= TOTAL_W'(count);
      overflow     <= ovf_seen;
    end
  end

  // Polygon state, cleared by reset and after each result.
  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      first_x  <= '0;
      first_y  <= '0;
      first_z  <= '0;
      prev_x   <= '0;
      prev_y   <= '0;
      prev_z   <= '0;
      acc_a    <= '0;
      acc_b    <= '0;
      acc_c    <= '0;
      sum_x    <= '0;
      sum_y    <= '0;
      sum_z    <= '0;
      count    <= '0;
      ovf_seen <= 1'b0;
      last_q   <= 1'b0;
      dot      <= '0;
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= cmd.mul_en;
      if (cmd.load_vertex) begin
        if (count == '0) begin
          first_x <= coord_x;
          first_y <= coord_y;
          first_z <= coord_z;
        end
        prev_x <= coord_x;
        prev_y <= coord_y;
        prev_z <= coord_z;
        sum_x  <= sum_x + SUM_W'(coord_x);
        sum_y  <= sum_y + SUM_W'(coord_y);
        sum_z  <= sum_z + SUM_W'(coord_z);
        if (count >= CNT_W'(MAX_VERTICES)) begin
          ovf_seen <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
        last_q <= is_last;
      end
      if (acc_en_q) begin
        unique case (acc_sel_q)
          SEL_EA: acc_a <= acc_a + prod[ACC_W-1:0];
          SEL_EB: acc_b <= acc_b + prod[ACC_W-1:0];
          SEL_EC: acc_c <= acc_c + prod[ACC_W-1:0];
          SEL_DXL, SEL_DYL, SEL_DZL: dot <= dot + DOT_W'(prod);
          SEL_DXH, SEL_DYH, SEL_DZH: dot <= dot + (DOT_W'(prod) <<< CHUNK_W);
          default: dot <= dot;
        endcase
      end
    end
  end

endmodule

// ===== rtl/polygon_plane_newell_unit.sv =====
// A vertex that does not close its polygon runs through its a, b and c edge products
// before the next vertex is taken. A closing vertex holds the unit through the closing
// edge, 6 dot-product steps and the bit-serial divider until its result is loaded.
// A result waiting at the output does not block the first vertices of the next polygon.
// Reset (synchronous, active high) clears all polygon state and drops the output item.
module polygon_plane_newell_unit #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 16
) (
  input  logic  clk,
  input  logic  rst,
  ppn_vertex_if.sink  vertex,
  ppn_plane_if.source plane
);
  import ppn_pkg::*;

  // The controller sequences each vertex through its a, b and c edge products on one
  // shared multiplier. On the closing vertex it adds the edge back to the first
  // vertex, forms the exact dot product of the coordinate sums and normal in six partial
  // products, and divides its magnitude by the vertex count one quotient bit per cycle.
  ppn_cmd_t    cmd;
  ppn_status_t status;

  ppn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex.valid),
    .in_ready  (vertex.ready),
    .out_valid (plane.valid),
    .out_ready (plane.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the polygon state, the multiplier, the divider and the
  // output item register.
  ppn_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .coord_x      (vertex.coord_x),
    .coord_y      (vertex.coord_y),
    .coord_z      (vertex.coord_z),
    .is_last      (vertex.is_last),
    .normal_a     (plane.normal_a),
    .normal_b     (plane.normal_b),
    .normal_c     (plane.normal_c),
    .offset_d     (plane.offset_d),
    .vertex_total (plane.vertex_total),
    .overflow     (plane.overflow)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ppn_pkg::*;

  // The block under test is built with these sizes, and the prediction below
  // works to the same ones.
  localparam int VERTEX_LIMIT = 256;
  localparam int COORD_W      = 16;

  // The safety net on the length of the run.  The slowest correct run has
  // every item close a polygon, every result wait out a receiver stall and the
  // one long hold-off, and stays well below this.
  localparam int CYCLE_LIMIT  = 1_000_000;

  // How long the receiver refuses results during the back-pressure test.
  localparam int HOLD_CYCLES  = 400;

  // Quiet time at the very end, longer than the time a closing vertex takes.
  localparam int TAIL_CYCLES  = 200;

  // The least number of random vertices in the random polygon test.
  localparam int RANDOM_ITEMS = 1020;

  // How the coordinates of one polygon are drawn.
  typedef enum int {
    SPAN_FULL,     // any 16 bit value
    SPAN_EXTREME,  // only the most negative, most positive and values near zero
    SPAN_NEAR      // values from -1024 to 1023 around the origin
  } coord_span_e;

  // One expected plane, at the widths of the output item.
  typedef struct {
    logic [ACC_W-1:0]   norm_a;
    logic [ACC_W-1:0]   norm_b;
    logic [ACC_W-1:0]   norm_c;
    logic [D_W-1:0]     offset;
    logic [TOTAL_W-1:0] total;
    logic               ovf;
  } plane_t;

  logic clk;
  logic rst;

  ppn_vertex_if #(.COORD_BITS(COORD_W)) vertex_ch ();
  ppn_plane_if                          plane_ch ();

  polygon_plane_newell_unit #(
    .MAX_VERTICES(VERTEX_LIMIT),
    .COORD_BITS  (COORD_W)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .vertex(vertex_ch.sink),
    .plane (plane_ch.source)
  );

  // Planes that the accepted vertices have produced and that have not yet come
  // out of the block, oldest first.
  plane_t plane_due[$];

  int mismatches = 0;
  int cycle_count = 0;
  int random_sent = 0;

  // When calm is set neither side idles, which gives a long stretch at full
  // rate.  The receiver's long hold-off is requested through hold_request and
  // counted down by the receiver itself.
  bit calm = 1'b0;
  logic hold_request = 1'b0;
  int hold_left = 0;

  // Our own copy of the polygon in progress.
  logic signed [COORD_W-1:0] first_x, first_y, first_z;
  logic signed [COORD_W-1:0] prev_x, prev_y, prev_z;
  logic [ACC_W-1:0] sum_norm_a, sum_norm_b, sum_norm_c;
  logic [SUM_W-1:0] coord_sum_x, coord_sum_y, coord_sum_z;
  int vertices_held;
  logic overflow_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is stopped here if the block hangs or stalls for good.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d planes still due", cycle_count,
               plane_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Start a fresh polygon: every accumulator, the count and the overflow flag
  // go back to zero, as they do at reset and after each closing vertex.
  function automatic void clear_polygon();
    first_x = '0;
    first_y = '0;
    first_z = '0;
    prev_x = '0;
    prev_y = '0;
    prev_z = '0;
    sum_norm_a = '0;
    sum_norm_b = '0;
    sum_norm_c = '0;
    coord_sum_x = '0;
    coord_sum_y = '0;
    coord_sum_z = '0;
    vertices_held = 0;
    overflow_seen = 1'b0;
  endfunction

  // Newell's terms for the edge from vertex i to vertex j.  The products are
  // formed exactly and then wrap into the 42 bit normal sums.
  function automatic void add_edge_terms(input logic signed [63:0] xi, yi, zi,
                                         input logic signed [63:0] xj, yj, zj);
    logic signed [63:0] term_a, term_b, term_c;
    term_a = (yi - yj) * (zi + zj);
    term_b = (zi - zj) * (xi + xj);
    term_c = (xi - xj) * (yi + yj);
    sum_norm_a = sum_norm_a + term_a[ACC_W-1:0];
    sum_norm_b = sum_norm_b + term_b[ACC_W-1:0];
    sum_norm_c = sum_norm_c + term_c[ACC_W-1:0];
  endfunction

  // Fold one accepted vertex into the polygon.  On the closing vertex the
  // edge back to the first vertex is added, the plane is worked out and
  // queued, and a new polygon begins.
  function automatic void fold_vertex(input logic signed [COORD_W-1:0] x, y, z,
                                      input logic last);
    plane_t plane;
    logic signed [127:0] sx, sy, sz, na, nb, nc, dot, count, quotient, neg_quotient;
    if (vertices_held == 0) begin
      first_x = x;
      first_y = y;
      first_z = z;
    end else begin
      add_edge_terms(prev_x, prev_y, prev_z, x, y, z);
    end
    coord_sum_x = coord_sum_x + {{(SUM_W - COORD_W){x[COORD_W-1]}}, x};
    coord_sum_y = coord_sum_y + {{(SUM_W - COORD_W){y[COORD_W-1]}}, y};
    coord_sum_z = coord_sum_z + {{(SUM_W - COORD_W){z[COORD_W-1]}}, z};
    // Beyond the limit the count holds and the overflow flag is raised, while
    // the sums carry on wrapping.
    if (vertices_held >= VERTEX_LIMIT) begin
      overflow_seen = 1'b1;
    end else begin
      vertices_held++;
    end
    prev_x = x;
    prev_y = y;
    prev_z = z;
    if (last) begin
      add_edge_terms(x, y, z, first_x, first_y, first_z);
      // d = -(sum . normal) / n with one division that truncates toward zero.
      // The dot product is exact in 128 bits, and the negated quotient is cut to the offset width.
      sx = $signed(coord_sum_x);
      sy = $signed(coord_sum_y);
      sz = $signed(coord_sum_z);
      na = $signed(sum_norm_a);
      nb = $signed(sum_norm_b);
      nc = $signed(sum_norm_c);
      dot = sx * na + sy * nb + sz * nc;
      count = vertices_held;
      quotient = dot / count;
      neg_quotient = -quotient;
      plane.norm_a = sum_norm_a;
      plane.norm_b = sum_norm_b;
      plane.norm_c = sum_norm_c;
      plane.offset = neg_quotient[D_W-1:0];
      plane.total = vertices_held[TOTAL_W-1:0];
      plane.ovf = overflow_seen;
      plane_due.push_back(plane);
      clear_polygon();
    end
  endfunction

  // Offer one vertex, idling beforehand at random unless calm is set, and
  // return on the edge at which the block takes it.  Valid stays high into
  // the next call when that call does not idle.
  task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, z,
                             input logic last);
    while (!calm && $urandom_range(99) < 11) begin
      vertex_ch.valid <= 1'b0;
      @(posedge clk);
    end
    vertex_ch.valid <= 1'b1;
    vertex_ch.coord_x <= x;
    vertex_ch.coord_y <= y;
    vertex_ch.coord_z <= z;
    vertex_ch.is_last <= last;
    @(posedge clk);
    while (!vertex_ch.ready) @(posedge clk);
    fold_vertex(x, y, z, last);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(input coord_span_e span);
    logic signed [COORD_W-1:0] value;
    case (span)
      SPAN_EXTREME: begin
        case ($urandom_range(4))
          0: value = 16'sh8000;
          1: value = 16'sh7fff;
          2: value = 16'sh0000;
          3: value = -16'sd1;
          default: value = 16'sd1;
        endcase
      end
      SPAN_NEAR: begin
        value = COORD_W'($signed($urandom_range(2047)) - 1024);
      end
      default: begin
        value = COORD_W'($urandom);
      end
    endcase
    return value;
  endfunction

  // A whole polygon of the given size, closed on its last vertex.
  task automatic send_polygon(input int size, input coord_span_e span);
    for (int i = 0; i < size; i++) begin
      send_vertex(pick_coord(span), pick_coord(span), pick_coord(span), i == size - 1);
    end
  endtask

  // Stop offering and wait until every plane due has come out.  Valid is
  // lowered before the loop, so that the next vertex never lowers and raises
  // it at the same edge.
  task automatic await_planes();
    vertex_ch.valid <= 1'b0;
    @(posedge clk);
    while (plane_due.size() != 0) @(posedge clk);
  endtask

  // The receiver: it takes results at random, holds off for a long stretch
  // when asked, and checks every result it takes against the oldest plane due.
  always @(posedge clk) begin : plane_side
    plane_t want;
    if (!rst && plane_ch.valid && plane_ch.ready) begin
      if (plane_due.size() == 0) begin
        report_mismatch("plane with none due, offset", plane_ch.offset_d, '0);
      end else begin
        want = plane_due.pop_front();
        if (plane_ch.normal_a !== want.norm_a)
          report_mismatch("normal_a", plane_ch.normal_a, want.norm_a);
        if (plane_ch.normal_b !== want.norm_b)
          report_mismatch("normal_b", plane_ch.normal_b, want.norm_b);
        if (plane_ch.normal_c !== want.norm_c)
          report_mismatch("normal_c", plane_ch.normal_c, want.norm_c);
        if (plane_ch.offset_d !== want.offset)
          report_mismatch("offset_d", plane_ch.offset_d, want.offset);
        if (plane_ch.vertex_total !== want.total)
          report_mismatch("vertex_total", plane_ch.vertex_total, want.total);
        if (plane_ch.overflow !== want.ovf)
          report_mismatch("overflow", plane_ch.overflow, want.ovf);
      end
    end
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= HOLD_CYCLES;
      plane_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      plane_ch.ready <= 1'b0;
    end else begin
      plane_ch.ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Hand-picked polygons: single vertices, which must give a zero plane, two
  // vertices, triangles at the corners of the coordinate range and a plain
  // square in the xy plane, one unit (256 in Q8.8) on a side.
  task automatic test_directed_shapes();
    send_vertex(16'sh8000, 16'sh7fff, 16'sh0000, 1'b1);
    send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    send_vertex(16'sh7fff, 16'sh8000, -16'sd1, 1'b1);

    send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);

    send_vertex(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
    send_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);

    send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_vertex(16'sh8000, 16'sh8000, 16'sh7fff, 1'b0);
    send_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);

    send_vertex(16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd256, 16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd256, 16'sd256, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd256, 16'sd0, 1'b1);

    // A tilted triangle whose offset is negative and divides evenly.
    send_vertex(16'sd3, 16'sd5, 16'sd7, 1'b0);
    send_vertex(-16'sd11, 16'sd13, 16'sd2, 1'b0);
    send_vertex(16'sd17, -16'sd19, 16'sd23, 1'b1);
    await_planes();
  endtask

  // Polygons at, just beyond and well beyond the vertex limit: the count must
  // hold at the limit and the overflow flag must be raised only past it.
  task automatic test_vertex_limit();
    send_polygon(VERTEX_LIMIT, SPAN_NEAR);
    send_polygon(VERTEX_LIMIT + 1, SPAN_FULL);
    send_polygon(VERTEX_LIMIT + 20, SPAN_NEAR);
    // The polygon after an overflow must start clean.
    send_polygon(3, SPAN_NEAR);
    await_planes();
  endtask

  // A long stretch at full rate on both sides.
  task automatic test_steady_stream();
    calm = 1'b1;
    for (int i = 0; i < 25; i++) begin
      send_polygon(1 + (i % 6), SPAN_FULL);
    end
    calm = 1'b0;
    await_planes();
  endtask

  // The receiver refuses results for a long stretch while triangles keep
  // coming, so the finished planes back up and the block stops taking
  // vertices.  Afterwards the sender waits for every plane before going on.
  task automatic test_output_backpressure();
    hold_request <= 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_polygon(3, SPAN_NEAR);
    end
    await_planes();
  endtask

  // Random polygons, mostly of a few vertices, with some single and two
  // vertex ones and a few longer ones, in the three coordinate spans.
  task automatic test_random_polygons();
    int size;
    int pick;
    coord_span_e span;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        size = $urandom_range(2, 1);
      end else if (pick < 92) begin
        size = $urandom_range(8, 3);
      end else begin
        size = $urandom_range(40, 9);
      end
      pick = $urandom_range(9);
      if (pick < 5) begin
        span = SPAN_FULL;
      end else if (pick < 8) begin
        span = SPAN_NEAR;
      end else begin
        span = SPAN_EXTREME;
      end
      send_polygon(size, span);
      random_sent += size;
    end
    await_planes();
  endtask

  initial begin
    rst = 1'b1;
    vertex_ch.valid = 1'b0;
    vertex_ch.coord_x = '0;
    vertex_ch.coord_y = '0;
    vertex_ch.coord_z = '0;
    vertex_ch.is_last = 1'b0;
    plane_ch.ready = 1'b0;
    clear_polygon();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed_shapes();
    test_vertex_limit();
    test_steady_stream();
    test_output_backpressure();
    test_random_polygons();

    // Let the block settle, so that a stray extra result would still be seen.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (plane_due.size() != 0) begin
      report_mismatch("planes never delivered", plane_due.size(), 0);
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== polygon_plane_newell_unit.f =====
rtl/ppn_pkg.sv
rtl/ppn_if.sv
rtl/ppn_ctrl.sv
rtl/ppn_datapath.sv
rtl/polygon_plane_newell_unit.sv
bench/testbench.sv
